/* src/ldl_pkg.sv */
package ldl_pkg;

    localparam int Q_W           = 32;
    localparam int DIVD_W        = 48;
    localparam int DIV_CELLS     = DIVD_W;
    localparam int CNT_W         = 7;
    localparam int IDX_W         = 4;
    localparam int ADDR_W        = 8;
    localparam int SIZE_W        = 4;
    localparam int TDATA_W       = 40;
    localparam int CFG_IDX_W     = 2;
    localparam int MAX_ORDER_DEF = 8;

    localparam logic [SIZE_W-1:0]    SIZE_RESET = 4'd8;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd1;

    typedef enum logic [3:0] {
        S_LOAD,
        S_RDV,
        S_GETV,
        S_GETA,
        S_GETB,
        S_GETD,
        S_MUL2,
        S_SUB,
        S_FIN,
        S_DIVW,
        S_ERD,
        S_ELAT,
        S_EHOLD
    } t_state;

    // One stage of the restoring divider: partial remainder and the shift
    // register that holds the remaining dividend bits and the quotient bits.
    typedef struct packed {
        logic              valid;
        logic              neg;
        logic [Q_W-1:0]    den;
        logic [Q_W-1:0]    rem;
        logic [DIVD_W-1:0] dq;
    } t_div_stage;

endpackage

/* src/ldl_decomposition_top.sv */
// LDL-transpose factorization of a symmetric n-by-n matrix in signed Q16.16.
// Input stream: one matrix element per transaction on the slave-side group,
// row-major. After the n*n-th element the block factors the matrix in place
// and then streams all n*n elements row-major on the master-side group:
// pivots on the diagonal, the unit upper factor above it, and the lower
// triangle as loaded. tlast marks the final element and tuser carries the
// failure flag (pivot below threshold, zero pivot or saturation).
// Configuration: matrix size (index 0) and pivot threshold (index 1) through
// the cfg channel, which is always ready; write them only while idle.
// Flow: loading takes one element per cycle. Factoring
// runs on one shared multiplier and a 48-cell restoring divider chain; each
// multiply-accumulate term takes three store reads at one read port, the
// first product taken with the last read, a second product and a subtract,
// and each off-diagonal entry waits for its quotient to leave the chain.
// Each output element is read from the store, latched and held until taken.
// The input side is not ready while factoring or emitting. When the receiver
// stalls, the current result holds in the output register and the block
// waits. Reset returns to loading with an empty count, size 8 and threshold
// 0; the element store itself is not cleared.
module ldl_decomposition_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [31:0] element_value
    input  logic [ldl_pkg::Q_W-1:0]           i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [31:0] factor_value, [34:32] row_index, [37:35] col_index, rest zero
    output logic [ldl_pkg::TDATA_W-1:0]       o_m_axis_tdata,
    output logic                              o_m_axis_tlast,
    // [0] pivot_failed
    output logic                              o_m_axis_tuser,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ldl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ldl_pkg::Q_W-1:0]           i_cfg_data
);

    localparam int MAX_ORDER = ldl_pkg::MAX_ORDER_DEF;
    localparam int DEPTH = MAX_ORDER * MAX_ORDER;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QW    = ldl_pkg::Q_W;
    localparam int IW    = ldl_pkg::IDX_W;

    ldl_pkg::t_state r_state, n_state;

    logic [ldl_pkg::CNT_W-1:0]  r_count, n_count;
    logic [IW-1:0]              r_i, n_i, r_j, n_j, r_k, n_k;
    logic [QW-1:0]              r_v, n_v, r_a, n_a, r_b, n_b, r_d, n_d;
    logic [QW-1:0]              r_p, n_p, r_t, n_t, r_piv, n_piv;
    logic                       r_fail, n_fail, r_dz, n_dz;
    logic [ldl_pkg::SIZE_W-1:0] r_size, n_size;
    logic [QW-1:0]              r_thr, n_thr;
    logic                       r_ovalid, n_ovalid, r_olast, n_olast;
    logic [QW-1:0]              r_oval, n_oval;
    logic [2:0]                 r_orow, n_orow, r_ocol, n_ocol;

    logic                       w_we;
    logic [AW-1:0]              w_waddr, w_raddr;
    logic [QW-1:0]              w_wdata, w_rdata;
    logic [IW-1:0]              w_n;
    logic [2*IW-1:0]            w_total;
    logic [ldl_pkg::CNT_W-1:0]  w_cnt_inc;

    logic signed [QW-1:0]       w_ma, w_mb;
    logic signed [2*QW-1:0]     w_prod, w_rnd;
    logic [QW-1:0]              w_mres;
    logic                       w_movf;
    logic [QW:0]                w_diff;
    logic [QW-1:0]              w_sres;
    logic                       w_sovf;
    logic [QW-1:0]              w_vmag, w_pmag;
    logic [ldl_pkg::DIVD_W-1:0] w_q;
    logic [QW-1:0]              w_qres;
    logic                       w_qovf;
    logic                       w_adv;

    ldl_pkg::t_div_stage w_div_in;
    ldl_pkg::t_div_stage w_lane [ldl_pkg::DIV_CELLS+1];

    function automatic logic [AW-1:0] f_addr(input logic [IW-1:0] a,
                                             input logic [IW-1:0] b,
                                             input logic [IW-1:0] n);
        logic [ldl_pkg::ADDR_W-1:0] s;
        s = ldl_pkg::ADDR_W'(a) * ldl_pkg::ADDR_W'(n) + ldl_pkg::ADDR_W'(b);
        return AW'(s);
    endfunction

    ldl_ram #(
        .WIDTH (QW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Divider chain: one quotient bit per cell, the operands march one cell
    // per cycle from the start lane to the result lane.
    genvar g;
    generate
        for (g = 0; g < ldl_pkg::DIV_CELLS; g++) begin : g_div
            ldl_div_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_stage (w_lane[g]),
                .o_stage (w_lane[g+1])
            );
        end
    endgenerate

    always_comb begin
        w_vmag = r_v[QW-1] ? QW'(-r_v) : r_v;
        w_pmag = r_piv[QW-1] ? QW'(-r_piv) : r_piv;
        w_div_in.valid = (r_state == ldl_pkg::S_FIN) && (r_j != r_i);
        w_div_in.neg   = r_v[QW-1] ^ r_piv[QW-1];
        w_div_in.den   = w_pmag;
        w_div_in.rem   = '0;
        w_div_in.dq    = {w_vmag, 16'd0};
    end

    assign w_lane[0] = w_div_in;

    // Effective order: zero acts as one, anything above the maximum is clamped.
    always_comb begin
        if (r_size == '0) begin
            w_n = IW'(1);
        end else if (int'(r_size) > MAX_ORDER) begin
            w_n = IW'(MAX_ORDER);
        end else begin
            w_n = r_size;
        end
        w_total   = (2*IW)'(w_n) * (2*IW)'(w_n);
        w_cnt_inc = r_count + 1'b1;
    end

    // Shared Q16.16 multiplier: round half up, then saturate.
    always_comb begin
        if (r_state == ldl_pkg::S_GETD) begin
            w_ma = r_a;
            w_mb = r_b;
        end else begin
            w_ma = r_p;
            w_mb = r_d;
        end
        w_prod = w_ma * w_mb;
        w_rnd  = (w_prod + 64'sd32768) >>> 16;
        w_movf = 1'b0;
        if (w_rnd > 64'sd2147483647) begin
            w_mres = 32'h7FFF_FFFF;
            w_movf = 1'b1;
        end else if (w_rnd < -64'sd2147483648) begin
            w_mres = 32'h8000_0000;
            w_movf = 1'b1;
        end else begin
            w_mres = w_rnd[QW-1:0];
        end
    end

    // Saturating subtract of the accumulated term.
    always_comb begin
        w_diff = {r_v[QW-1], r_v} - {r_t[QW-1], r_t};
        w_sovf = (w_diff[QW] != w_diff[QW-1]);
        if (!w_sovf) begin
            w_sres = w_diff[QW-1:0];
        end else if (w_diff[QW]) begin
            w_sres = 32'h8000_0000;
        end else begin
            w_sres = 32'h7FFF_FFFF;
        end
    end

    // Sign and saturation of the quotient leaving the divider chain.
    always_comb begin
        w_q    = w_lane[ldl_pkg::DIV_CELLS].dq;
        w_qovf = 1'b0;
        if (w_lane[ldl_pkg::DIV_CELLS].neg) begin
            if (w_q > 48'h0000_8000_0000) begin
                w_qres = 32'h8000_0000;
                w_qovf = 1'b1;
            end else begin
                w_qres = QW'(-w_q[QW-1:0]);
            end
        end else if (w_q > 48'h0000_7FFF_FFFF) begin
            w_qres = 32'h7FFF_FFFF;
            w_qovf = 1'b1;
        end else begin
            w_qres = w_q[QW-1:0];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        n_v      = r_v;
        n_a      = r_a;
        n_b      = r_b;
        n_d      = r_d;
        n_p      = r_p;
        n_t      = r_t;
        n_piv    = r_piv;
        n_fail   = r_fail;
        n_dz     = r_dz;
        n_size   = r_size;
        n_thr    = r_thr;
        n_ovalid = r_ovalid;
        n_olast  = r_olast;
        n_oval   = r_oval;
        n_orow   = r_orow;
        n_ocol   = r_ocol;
        w_we     = 1'b0;
        w_waddr  = AW'(r_count);
        w_wdata  = i_s_axis_tdata;
        w_raddr  = f_addr(r_i, r_j, w_n);
        w_adv    = 1'b0;

        if (i_cfg_valid) begin
            if (i_cfg_index == ldl_pkg::REG_SIZE) begin
                n_size = i_cfg_data[ldl_pkg::SIZE_W-1:0];
            end else if (i_cfg_index == ldl_pkg::REG_THRESH) begin
                n_thr = i_cfg_data;
            end
        end

        unique case (r_state)
            ldl_pkg::S_LOAD: begin
                if (i_s_axis_tvalid) begin
                    w_we = (int'(r_count) < DEPTH);
                    if ((2*IW)'(w_cnt_inc) >= w_total) begin
                        n_count = '0;
                        n_fail  = 1'b0;
                        n_i     = '0;
                        n_j     = '0;
                        n_k     = '0;
                        n_state = ldl_pkg::S_RDV;
                    end else begin
                        n_count = w_cnt_inc;
                    end
                end
            end
            ldl_pkg::S_RDV: begin
                w_raddr = f_addr(r_i, r_j, w_n);
                n_k     = '0;
                n_state = ldl_pkg::S_GETV;
            end
            ldl_pkg::S_GETV: begin
                n_v     = w_rdata;
                w_raddr = f_addr(r_k, r_i, w_n);
                n_state = (r_k < r_i) ? ldl_pkg::S_GETA : ldl_pkg::S_FIN;
            end
            ldl_pkg::S_GETA: begin
                n_a     = w_rdata;
                w_raddr = f_addr(r_k, r_j, w_n);
                n_state = ldl_pkg::S_GETB;
            end
            ldl_pkg::S_GETB: begin
                n_b     = w_rdata;
                w_raddr = f_addr(r_k, r_k, w_n);
                n_state = ldl_pkg::S_GETD;
            end
            ldl_pkg::S_GETD: begin
                n_d     = w_rdata;
                n_p     = w_mres;
                n_fail  = r_fail | w_movf;
                n_state = ldl_pkg::S_MUL2;
            end
            ldl_pkg::S_MUL2: begin
                n_t     = w_mres;
                n_fail  = r_fail | w_movf;
                n_state = ldl_pkg::S_SUB;
            end
            ldl_pkg::S_SUB: begin
                n_v     = w_sres;
                n_fail  = r_fail | w_sovf;
                n_k     = r_k + 1'b1;
                w_raddr = f_addr(r_k + 1'b1, r_i, w_n);
                n_state = ((r_k + 1'b1) < r_i) ? ldl_pkg::S_GETA : ldl_pkg::S_FIN;
            end
            ldl_pkg::S_FIN: begin
                if (r_j == r_i) begin
                    // Diagonal: the pivot is final once written.
                    w_we    = 1'b1;
                    w_waddr = f_addr(r_i, r_i, w_n);
                    w_wdata = r_v;
                    n_piv   = r_v;
                    if ($signed(r_v) < $signed(r_thr)) begin
                        n_fail = 1'b1;
                    end
                    w_adv = 1'b1;
                end else begin
                    n_dz    = (r_piv == '0);
                    n_state = ldl_pkg::S_DIVW;
                end
            end
            ldl_pkg::S_DIVW: begin
                if (w_lane[ldl_pkg::DIV_CELLS].valid) begin
                    w_we    = 1'b1;
                    w_waddr = f_addr(r_i, r_j, w_n);
                    w_wdata = r_dz ? '0 : w_qres;
                    n_fail  = r_fail | r_dz | w_qovf;
                    w_adv   = 1'b1;
                end
            end
            ldl_pkg::S_ERD: begin
                w_raddr = f_addr(r_i, r_j, w_n);
                n_state = ldl_pkg::S_ELAT;
            end
            ldl_pkg::S_ELAT: begin
                n_oval   = w_rdata;
                n_orow   = r_i[2:0];
                n_ocol   = r_j[2:0];
                n_olast  = (r_i == w_n - 1'b1) && (r_j == w_n - 1'b1);
                n_ovalid = 1'b1;
                n_state  = ldl_pkg::S_EHOLD;
            end
            ldl_pkg::S_EHOLD: begin
                if (i_m_axis_tready) begin
                    n_ovalid = 1'b0;
                    if (r_olast) begin
                        n_i     = '0;
                        n_j     = '0;
                        n_state = ldl_pkg::S_LOAD;
                    end else if (r_j + 1'b1 < w_n) begin
                        n_j     = r_j + 1'b1;
                        n_state = ldl_pkg::S_ERD;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_j     = '0;
                        n_state = ldl_pkg::S_ERD;
                    end
                end
            end
            default: begin
                n_state = ldl_pkg::S_LOAD;
            end
        endcase

        // Step to the next entry of the upper triangle, or on to output.
        if (w_adv) begin
            if (r_j + 1'b1 < w_n) begin
                n_j     = r_j + 1'b1;
                n_state = ldl_pkg::S_RDV;
            end else if (r_i + 1'b1 < w_n) begin
                n_i     = r_i + 1'b1;
                n_j     = r_i + 1'b1;
                n_state = ldl_pkg::S_RDV;
            end else begin
                n_i     = '0;
                n_j     = '0;
                n_state = ldl_pkg::S_ERD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_v     <= n_v;
        r_a     <= n_a;
        r_b     <= n_b;
        r_d     <= n_d;
        r_p     <= n_p;
        r_t     <= n_t;
        r_piv   <= n_piv;
        r_dz    <= n_dz;
        r_k     <= n_k;
        r_oval  <= n_oval;
        r_orow  <= n_orow;
        r_ocol  <= n_ocol;
        r_olast <= n_olast;
        if (!i_rst_n) begin
            r_state  <= ldl_pkg::S_LOAD;
            r_count  <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_fail   <= 1'b0;
            r_size   <= ldl_pkg::SIZE_RESET;
            r_thr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_i      <= n_i;
            r_j      <= n_j;
            r_fail   <= n_fail;
            r_size   <= n_size;
            r_thr    <= n_thr;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_s_axis_tready = (r_state == ldl_pkg::S_LOAD);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {2'b00, r_ocol, r_orow, r_oval};
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tuser  = r_fail;

endmodule

/* src/ldl_ram.sv */
module ldl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                    i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                    o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/ldl_div_cell.sv */
module ldl_div_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ldl_pkg::t_div_stage   i_stage,
    output ldl_pkg::t_div_stage   o_stage
);

    logic [ldl_pkg::Q_W:0] w_rs;
    logic                  w_ge;
    ldl_pkg::t_div_stage   n_stage;
    ldl_pkg::t_div_stage   r_stage;

    // Shift one dividend bit into the remainder and try to subtract the divisor.
    always_comb begin
        w_rs = {i_stage.rem, i_stage.dq[ldl_pkg::DIVD_W-1]};
        w_ge = (w_rs >= {1'b0, i_stage.den});
        n_stage       = i_stage;
        n_stage.rem   = w_ge ? ldl_pkg::Q_W'(w_rs - {1'b0, i_stage.den})
                             : w_rs[ldl_pkg::Q_W-1:0];
        n_stage.dq    = {i_stage.dq[ldl_pkg::DIVD_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;

    typedef logic signed [ldl_pkg::Q_W-1:0] t_q;

    // One element of a factored matrix as it should leave the block.
    typedef struct {
        logic [ldl_pkg::Q_W-1:0] value;
        logic [2:0]              row;
        logic [2:0]              col;
        logic                    last;
        logic                    fail;
    } t_factor_entry;

    localparam int ORDER = 8;
    localparam int DEPTH = ORDER * ORDER;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [ldl_pkg::Q_W-1:0]       s_data = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [ldl_pkg::TDATA_W-1:0]   m_data;
    logic                          m_last;
    logic                          m_user;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [ldl_pkg::CFG_IDX_W-1:0] cfg_index = ldl_pkg::REG_SIZE;
    logic [ldl_pkg::Q_W-1:0]       cfg_data = '0;

    ldl_decomposition_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .o_m_axis_tuser  (m_user),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // Shadow copy of the block: element store, load counter and registers.
    t_q          elem_store [DEPTH];
    int unsigned elems_loaded;
    logic        factor_fail;
    logic [3:0]  size_reg;
    t_q          threshold_reg;

    t_q            element_queue [$];
    t_factor_entry factor_queue [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int checked        = 0;
    int matrices_done  = 0;
    int failed_mats    = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Timeout: %0d results still expected", factor_queue.size());
        $display("Simulation FAILED");
        $finish;
    end

    // Saturate to 32 bits; any clipping marks the matrix as failed.
    function automatic t_q clamp_q(longint v);
        if (v > longint'(32'sh7FFFFFFF)) begin
            factor_fail = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -longint'(64'sh80000000)) begin
            factor_fail = 1'b1;
            return 32'sh80000000;
        end
        return t_q'(v);
    endfunction

    // Q16.16 product, rounded to nearest with ties upward.
    function automatic t_q qmul(t_q a, t_q b);
        longint p;
        p = longint'(a) * longint'(b) + 64'sd32768;
        return clamp_q(p >>> 16);
    endfunction

    function automatic t_q qdiv(t_q num, t_q den);
        longint quo;
        if (den == 0) begin
            factor_fail = 1'b1;
            return '0;
        end
        quo = (longint'(num) * 64'sd65536) / longint'(den);
        return clamp_q(quo);
    endfunction

    // In-place LDL-transpose on the first n*n stored elements.
    task automatic factor_matrix(int n);
        t_q acc;
        t_q v;
        t_q t;
        for (int i = 0; i < n; i++) begin
            acc = elem_store[i*n+i];
            for (int k = 0; k < i; k++) begin
                t = qmul(qmul(elem_store[k*n+i], elem_store[k*n+i]), elem_store[k*n+k]);
                acc = clamp_q(longint'(acc) - longint'(t));
            end
            elem_store[i*n+i] = acc;
            for (int j = i + 1; j < n; j++) begin
                v = elem_store[i*n+j];
                for (int k = 0; k < i; k++) begin
                    t = qmul(qmul(elem_store[k*n+i], elem_store[k*n+j]),
                             elem_store[k*n+k]);
                    v = clamp_q(longint'(v) - longint'(t));
                end
                elem_store[i*n+j] = qdiv(v, acc);
            end
        end
        for (int i = 0; i < n; i++)
            if (elem_store[i*n+i] < threshold_reg) factor_fail = 1'b1;
    endtask

    // Takes one accepted element; on the completing element queues the
    // whole factored matrix.
    task automatic absorb_element(t_q x);
        int n;
        int total;
        t_factor_entry e;
        n = (size_reg == 0) ? 1 : (size_reg > ORDER) ? ORDER : int'(size_reg);
        total = n * n;
        if (elems_loaded < DEPTH) elem_store[elems_loaded] = x;
        elems_loaded = (elems_loaded + 1) & 7'h7F;
        if (elems_loaded < total) return;
        elems_loaded = 0;
        factor_fail = 1'b0;
        factor_matrix(n);
        for (int idx = 0; idx < total; idx++) begin
            e.value = elem_store[idx];
            e.row   = 3'(idx / n);
            e.col   = 3'(idx % n);
            e.last  = (idx == total - 1);
            e.fail  = factor_fail;
            factor_queue.push_back(e);
        end
        matrices_done++;
        if (factor_fail) failed_mats++;
    endtask

    // Element driver: a held transaction stays on the bus until accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) absorb_element(s_data);
            if (!s_valid || s_ready) begin
                if (element_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= element_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge i_clk) begin
        t_factor_entry e;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (factor_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result: data %h last %b user %b",
                                 m_data, m_last, m_user);
                end else begin
                    e = factor_queue.pop_front();
                    checked++;
                    if (m_data[31:0] !== e.value || m_data[34:32] !== e.row ||
                        m_data[37:35] !== e.col || m_last !== e.last ||
                        m_user !== e.fail) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("Mismatch at (%0d,%0d): expected %h last %b fail %b",
                                     e.row, e.col, e.value, e.last, e.fail);
                            $display("    got %h row %0d col %0d last %b fail %b",
                                     m_data[31:0], m_data[34:32], m_data[37:35],
                                     m_last, m_user);
                        end
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Waits until every queued element is taken and every result is back,
    // then lets the block finish any internal work.
    task automatic drain;
        while (element_queue.size() > 0 || s_valid || factor_queue.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [ldl_pkg::CFG_IDX_W-1:0] idx,
                             logic [ldl_pkg::Q_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == ldl_pkg::REG_SIZE) size_reg = val[ldl_pkg::SIZE_W-1:0];
        else threshold_reg = t_q'(val);
    endtask

    // Queues one n-by-n matrix: well-conditioned, symmetric with wider values, or raw noise.
    task automatic queue_matrix(int n, int kind);
        t_q m [ORDER][ORDER];
        int rowsum;
        for (int i = 0; i < n; i++) begin
            for (int j = i; j < n; j++) begin
                case (kind)
                    0:       m[i][j] = t_q'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
                    1:       m[i][j] = t_q'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
                    default: m[i][j] = t_q'($urandom);
                endcase
                m[j][i] = (kind == 2) ? t_q'($urandom) : m[i][j];
            end
        end
        if (kind == 0) begin
            for (int i = 0; i < n; i++) begin
                rowsum = n << 17;
                m[i][i] = t_q'(rowsum + int'($urandom_range(0, 1 << 20)));
            end
        end
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                element_queue.push_back(m[i][j]);
    endtask

    initial begin
        int n;
        int kind;
        int rand_items;
        int pick;
        elems_loaded  = 0;
        factor_fail   = 1'b0;
        size_reg      = ldl_pkg::SIZE_RESET;
        threshold_reg = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Single-element matrices: zero pivot, largest,
        // most negative and one.
        write_reg(ldl_pkg::REG_SIZE, 32'd1);
        write_reg(ldl_pkg::REG_THRESH, 32'd0);
        element_queue.push_back(32'sh00000000);
        element_queue.push_back(32'sh7FFFFFFF);
        element_queue.push_back(32'sh80000000);
        element_queue.push_back(32'sh00010000);
        // Two-by-two cases that saturate in the division and the subtraction.
        drain();
        write_reg(ldl_pkg::REG_SIZE, 32'd2);
        element_queue.push_back(32'sh80000000);
        element_queue.push_back(32'sh7FFFFFFF);
        element_queue.push_back(32'sh00000000);
        element_queue.push_back(32'sh00000001);
        element_queue.push_back(32'sh00010000);
        element_queue.push_back(32'sh7FFFFFFF);
        element_queue.push_back(32'sh00000000);
        element_queue.push_back(32'shFFFFFFFF);
        // Size zero behaves as one; lowest threshold never flags a pivot.
        drain();
        write_reg(ldl_pkg::REG_SIZE, 32'd0);
        write_reg(ldl_pkg::REG_THRESH, 32'h80000000);
        element_queue.push_back(32'sh80000000);
        drain();
        write_reg(ldl_pkg::REG_SIZE, 32'd2);
        element_queue.push_back(32'sh00020000);
        element_queue.push_back(32'sh00008000);
        element_queue.push_back(32'sh00008000);
        element_queue.push_back(32'sh00030000);
        // Highest threshold flags any pivot below it.
        drain();
        write_reg(ldl_pkg::REG_THRESH, 32'h7FFFFFFF);
        write_reg(ldl_pkg::REG_SIZE, 32'd1);
        element_queue.push_back(32'sh7FFFFFFE);
        // Size shrinks mid-load: the count is kept and the next element
        // completes a two-by-two from the first four stored elements.
        drain();
        write_reg(ldl_pkg::REG_THRESH, 32'd0);
        write_reg(ldl_pkg::REG_SIZE, 32'd3);
        repeat (5) element_queue.push_back(t_q'($urandom_range(0, 1 << 19)));
        drain();
        write_reg(ldl_pkg::REG_SIZE, 32'd2);
        element_queue.push_back(32'sh00010000);
        drain();

        // Random part in four idling phases.
        rand_items = 0;
        while (rand_items < 460) begin
            case (rand_items * 4 / 460)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            if ($urandom_range(3) == 0) begin
                drain();
                pick = $urandom_range(99);
                n = (pick < 70) ? $urandom_range(1, 4) : (pick < 92) ? $urandom_range(5, 7) : 8;
                if (n == 1 && $urandom_range(1))
                    write_reg(ldl_pkg::REG_SIZE, 32'd0);
                else if (n == 8 && $urandom_range(1))
                    write_reg(ldl_pkg::REG_SIZE, $urandom_range(9, 15));
                else
                    write_reg(ldl_pkg::REG_SIZE, 32'(n));
                case ($urandom_range(4))
                    0: write_reg(ldl_pkg::REG_THRESH, 32'h80000000);
                    1: write_reg(ldl_pkg::REG_THRESH, 32'h7FFFFFFF);
                    2: write_reg(ldl_pkg::REG_THRESH, $urandom);
                    3: write_reg(ldl_pkg::REG_THRESH,
                                 32'(int'($urandom_range(0, 1 << 18)) - (1 << 17)));
                    default: write_reg(ldl_pkg::REG_THRESH, 32'd0);
                endcase
            end
            n = (size_reg == 0) ? 1 : (size_reg > ORDER) ? ORDER : int'(size_reg);
            pick = $urandom_range(99);
            kind = (pick < 60) ? 0 : (pick < 85) ? 1 : 2;
            queue_matrix(n, kind);
            rand_items += n * n;
        end

        drain();
        repeat (60) @(posedge i_clk);
        if (factor_queue.size() != 0) mismatches++;
        $display("Factored %0d matrices (%0d flagged as failed), %0d elements checked.",
                 matrices_done, failed_mats, checked);
        $display("Sizes 1 to 8 with out-of-range size codes, threshold extremes and stalls.");
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
